[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define EFR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true on a clock edge outside reset.
`define EFR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/efr_pkg.sv]
// ----------------------------------------------------------------------------
// efr_pkg
// Types and constants shared by the escaped frame receiver modules.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int unsigned BufferDepth = 1024;
  localparam int unsigned WpW         = $clog2(BufferDepth);
  localparam int unsigned PosW        = 10;
  localparam int unsigned LenW        = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] EscXor       = 8'h20;
  localparam logic [ByteW-1:0] SumGood      = 8'hFF;
  localparam logic [ByteW-1:0] DelimReset   = 8'd126;
  localparam logic [ByteW-1:0] EscapeReset  = 8'd125;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELIMITER = 1'b0,
    CFG_ESCAPE    = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    TOK_DELIM = 1'b0,
    TOK_BYTE  = 1'b1
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e        kind;
    logic [ByteW-1:0] data;
  } efr_tok_t;

  typedef enum logic {
    RES_DATA   = 1'b0,
    RES_RECORD = 1'b1
  } res_kind_e;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_TYPE   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } efr_qstat_t;

endpackage

[hw/rtl/efr_front.sv]
// ----------------------------------------------------------------------------
// efr_front
// Holds the delimiter and escape registers, strips byte escaping and turns
// each non-escape byte into a delimiter or data token for the queue.
// ----------------------------------------------------------------------------
module efr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [efr_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [efr_pkg::ByteW-1:0]    rx_byte_i,
  input  efr_pkg::efr_qstat_t          qstat_i,
  output logic                         push_o,
  output efr_pkg::efr_tok_t            tok_o
);

  logic [efr_pkg::ByteW-1:0] delim_q, delim_d;
  logic [efr_pkg::ByteW-1:0] esc_byte_q, esc_byte_d;
  logic                      esc_pend_q, esc_pend_d;
  logic                      accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;

  always_comb begin
    delim_d    = delim_q;
    esc_byte_d = esc_byte_q;
    if (cfg_we_i) begin
      unique case (efr_pkg::cfg_reg_e'(cfg_index_i))
        efr_pkg::CFG_DELIMITER: delim_d    = cfg_wdata_i;
        efr_pkg::CFG_ESCAPE:    esc_byte_d = cfg_wdata_i;
        default:                delim_d    = delim_q;
      endcase
    end
  end

  // Delimiter wins over escape; an escape byte only arms the pending flag
  always_comb begin
    esc_pend_d = esc_pend_q;
    push_o     = 1'b0;
    tok_o.kind = efr_pkg::TOK_BYTE;
    tok_o.data = rx_byte_i;
    if (accept) begin
      priority if (rx_byte_i == delim_q) begin
        esc_pend_d = 1'b0;
        push_o     = 1'b1;
        tok_o.kind = efr_pkg::TOK_DELIM;
      end else if (rx_byte_i == esc_byte_q) begin
        esc_pend_d = 1'b1;
      end else begin
        esc_pend_d = 1'b0;
        push_o     = 1'b1;
        if (esc_pend_q) begin
          tok_o.data = rx_byte_i ^ efr_pkg::EscXor;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= efr_pkg::DelimReset;
      esc_byte_q <= efr_pkg::EscapeReset;
      esc_pend_q <= 1'b0;
    end else begin
      delim_q    <= delim_d;
      esc_byte_q <= esc_byte_d;
      esc_pend_q <= esc_pend_d;
    end
  end

endmodule

[hw/rtl/efr_queue.sv]
// ----------------------------------------------------------------------------
// efr_queue
// Short token queue between the front and back halves of the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  efr_pkg::efr_tok_t   tok_i,
  input  logic                pop_i,
  output efr_pkg::efr_tok_t   head_o,
  output efr_pkg::efr_qstat_t qstat_o
);

  efr_pkg::efr_tok_t                entry_q [efr_pkg::QueueDepth];
  logic [efr_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [efr_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [efr_pkg::QCntW-1:0]        cnt_q, cnt_d;

  localparam logic [efr_pkg::QPtrW-1:0] PtrLast = efr_pkg::QPtrW'(efr_pkg::QueueDepth - 1);
  localparam logic [efr_pkg::QCntW-1:0] CntFull = efr_pkg::QCntW'(efr_pkg::QueueDepth);

  assign qstat_o.full  = (cnt_q == CntFull);
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= tok_i;
    end
  end

  `EFR_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && qstat_o.full, "queue overflow")
  `EFR_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && qstat_o.empty, "queue underflow")
  `EFR_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntFull, "queue count out of range")

endmodule

[hw/rtl/efr_back.sv]
// ----------------------------------------------------------------------------
// efr_back
// Frame parser: walks length, type, data and checksum, emits data bytes with
// their buffer position and a record for each frame with a good checksum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  efr_pkg::efr_tok_t           head_i,
  input  efr_pkg::efr_qstat_t         qstat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic [efr_pkg::ByteW-1:0]   data_byte_o,
  output logic [efr_pkg::PosW-1:0]    byte_position_o,
  output logic [efr_pkg::ByteW-1:0]   frame_kind_o,
  output logic [efr_pkg::PosW-1:0]    frame_start_o,
  output logic [efr_pkg::LenW-1:0]    payload_length_o
);

  efr_pkg::phase_e                 phase_q, phase_d;
  logic [efr_pkg::LenW-1:0]        decl_q, decl_d;
  logic [efr_pkg::LenW-1:0]        cnt_q, cnt_d;
  logic [efr_pkg::LenW-1:0]        cnt_inc;
  logic [efr_pkg::ByteW-1:0]       sum_q, sum_d;
  logic [efr_pkg::ByteW-1:0]       sum_new;
  logic [efr_pkg::ByteW-1:0]       type_q, type_d;
  logic [efr_pkg::WpW-1:0]         start_q, start_d;
  logic [efr_pkg::WpW-1:0]         wp_q, wp_d;

  logic                            res_valid;
  efr_pkg::res_kind_e              res_kind;
  logic [efr_pkg::ByteW-1:0]       res_data;
  logic [efr_pkg::PosW-1:0]        res_pos;
  logic [efr_pkg::ByteW-1:0]       res_type;
  logic [efr_pkg::PosW-1:0]        res_start;
  logic [efr_pkg::LenW-1:0]        res_len;

  logic                            out_valid_q;
  logic                            out_kind_q;
  logic [efr_pkg::ByteW-1:0]       out_data_q;
  logic [efr_pkg::PosW-1:0]        out_pos_q;
  logic [efr_pkg::ByteW-1:0]       out_type_q;
  logic [efr_pkg::PosW-1:0]        out_start_q;
  logic [efr_pkg::LenW-1:0]        out_len_q;

  localparam logic [efr_pkg::WpW-1:0] WpLast = efr_pkg::WpW'(efr_pkg::BufferDepth - 1);

  // Every token yields at most one result, so a free output slot is enough
  assign pop_o   = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign cnt_inc = cnt_q + 1'b1;
  assign sum_new = sum_q + head_i.data;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      if (head_i.kind == efr_pkg::TOK_DELIM) begin
        phase_d = efr_pkg::PH_LEN_HI;
      end else begin
        unique case (phase_q)
          efr_pkg::PH_WAIT:   phase_d = efr_pkg::PH_WAIT;
          efr_pkg::PH_LEN_HI: phase_d = efr_pkg::PH_LEN_LO;
          efr_pkg::PH_LEN_LO: phase_d = efr_pkg::PH_TYPE;
          efr_pkg::PH_TYPE:   phase_d = (decl_q <= efr_pkg::LenW'(1)) ?
                                        efr_pkg::PH_CHECK : efr_pkg::PH_DATA;
          efr_pkg::PH_DATA:   phase_d = (cnt_inc == decl_q) ?
                                        efr_pkg::PH_CHECK : efr_pkg::PH_DATA;
          efr_pkg::PH_CHECK:  phase_d = efr_pkg::PH_WAIT;
          default:            phase_d = efr_pkg::PH_WAIT;
        endcase
      end
    end
  end

  // Frame fields and result
  always_comb begin
    decl_d    = decl_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    type_d    = type_q;
    start_d   = start_q;
    wp_d      = wp_q;
    res_valid = 1'b0;
    res_kind  = efr_pkg::RES_DATA;
    res_data  = '0;
    res_pos   = '0;
    res_type  = '0;
    res_start = '0;
    res_len   = '0;
    if (pop_o) begin
      if (head_i.kind == efr_pkg::TOK_DELIM) begin
        decl_d = '0;
        cnt_d  = '0;
        sum_d  = '0;
      end else begin
        unique case (phase_q)
          efr_pkg::PH_LEN_HI: decl_d = {head_i.data, decl_q[efr_pkg::ByteW-1:0]};
          efr_pkg::PH_LEN_LO: decl_d = {decl_q[efr_pkg::LenW-1:efr_pkg::ByteW], head_i.data};
          efr_pkg::PH_TYPE: begin
            type_d  = head_i.data;
            sum_d   = sum_new;
            cnt_d   = efr_pkg::LenW'(1);
            start_d = wp_q;
          end
          efr_pkg::PH_DATA: begin
            res_valid = 1'b1;
            res_kind  = efr_pkg::RES_DATA;
            res_data  = head_i.data;
            res_pos   = efr_pkg::PosW'(wp_q);
            wp_d      = (wp_q == WpLast) ? '0 : wp_q + 1'b1;
            sum_d     = sum_new;
            cnt_d     = cnt_inc;
          end
          efr_pkg::PH_CHECK: begin
            sum_d = sum_new;
            if (sum_new == efr_pkg::SumGood) begin
              res_valid = 1'b1;
              res_kind  = efr_pkg::RES_RECORD;
              res_type  = type_q;
              res_start = efr_pkg::PosW'(start_q);
              res_len   = cnt_q - 1'b1;
            end
          end
          default: begin
            // ignore bytes outside a frame
            decl_d = decl_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= efr_pkg::PH_WAIT;
      decl_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      type_q      <= '0;
      start_q     <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      decl_q  <= decl_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      start_q <= start_d;
      wp_q    <= wp_d;
      if (pop_o) begin
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output slot only when a token is consumed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_kind_q  <= res_kind;
      out_data_q  <= res_data;
      out_pos_q   <= res_pos;
      out_type_q  <= res_type;
      out_start_q <= res_start;
      out_len_q   <= res_len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_kind_q;
  assign data_byte_o      = out_data_q;
  assign byte_position_o  = out_pos_q;
  assign frame_kind_o     = out_type_q;
  assign frame_start_o    = out_start_q;
  assign payload_length_o = out_len_q;

  `EFR_ASSERT(a_data_cnt_below_len, clk_i, rst_ni,
              (phase_q == efr_pkg::PH_DATA) |-> (cnt_q < decl_q),
              "data phase with count not below declared length")
  `EFR_ASSERT(a_record_from_check, clk_i, rst_ni,
              (res_valid && res_kind == efr_pkg::RES_RECORD) |-> (phase_q == efr_pkg::PH_CHECK),
              "frame record outside checksum phase")
  `EFR_ASSERT(a_data_yields_output, clk_i, rst_ni,
              (pop_o && head_i.kind == efr_pkg::TOK_BYTE && phase_q == efr_pkg::PH_DATA)
              |=> out_valid_q,
              "data byte produced no output")

endmodule

[hw/rtl/escaped_frame_receiver_core.sv]
// Path: a data byte or frame record is queued at the edge its byte is transferred
// in, then offered from the output register once the parser takes its token.
// Throughput: one byte per cycle, sustained while the output is not stalled.
// The 2-entry token queue sets how far the input may run ahead of a stall.
// Reset: asynchronous, active low; delimiter 126, escape 125, parser waiting.
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core
// Receives escaped serial bytes and emits buffer data bytes and frame records.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [efr_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [efr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic [efr_pkg::ByteW-1:0]   data_byte_o,
  output logic [efr_pkg::PosW-1:0]    byte_position_o,
  output logic [efr_pkg::ByteW-1:0]   frame_kind_o,
  output logic [efr_pkg::PosW-1:0]    frame_start_o,
  output logic [efr_pkg::LenW-1:0]    payload_length_o
);

  efr_pkg::efr_qstat_t qstat;
  efr_pkg::efr_tok_t   push_tok;
  efr_pkg::efr_tok_t   head_tok;
  logic                push;
  logic                pop;

  efr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .tok_o       (push_tok)
  );

  efr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .pop_i   (pop),
    .head_o  (head_tok),
    .qstat_o (qstat)
  );

  efr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_tok),
    .qstat_i          (qstat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .data_byte_o      (data_byte_o),
    .byte_position_o  (byte_position_o),
    .frame_kind_o     (frame_kind_o),
    .frame_start_o    (frame_start_o),
    .payload_length_o (payload_length_o)
  );

endmodule
